>>> rtl/core/tcce_pkg.sv
package tcce_pkg;

   localparam int CODE_W   = 21;
   localparam int COLOR_W  = 4;
   localparam int RGB_W    = 16;
   localparam int ROWCOL_W = 8;
   localparam int CROW_W   = 5;
   localparam int CCOL_W   = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CODE_W-1:0]    CODE_NEWLINE = CODE_W'(10);
   localparam logic [CODE_W-1:0]    CODE_SPACE   = CODE_W'(32);
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = CSR_IDX_W'(1);
   localparam logic [COLOR_W-1:0]   FG_RESET     = COLOR_W'(14);
   localparam logic [COLOR_W-1:0]   BG_RESET     = COLOR_W'(6);

   typedef enum logic [1:0] {
      OP_PUT        = 2'd0,
      OP_SET_CURSOR = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_READ       = 2'd3
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CODE_W-1:0]     code;
      logic [ROWCOL_W-1:0]   row;
      logic [ROWCOL_W-1:0]   column;
   } req_type;

   typedef struct packed {
      logic                  cell_valid;
      logic [CROW_W-1:0]     cell_row;
      logic [CCOL_W-1:0]     cell_column;
      logic [CODE_W-1:0]     cell_code;
      logic [COLOR_W-1:0]    cell_fg;
      logic [COLOR_W-1:0]    cell_bg;
      logic [RGB_W-1:0]      fg_rgb565;
      logic [RGB_W-1:0]      bg_rgb565;
      logic [CROW_W-1:0]     cursor_row;
      logic [CCOL_W-1:0]     cursor_column;
      logic                  scrolled;
   } rsp_type;

   // One character cell as held in the store.
   typedef struct packed {
      logic [CODE_W-1:0]     code;
      logic [COLOR_W-1:0]    fg;
      logic [COLOR_W-1:0]    bg;
   } cell_type;

   localparam logic [RGB_W-1:0] PALETTE [16] = '{
      16'h0000, 16'hFFFF, 16'hA208, 16'h7BFE, 16'hB0B0, 16'h4FEC, 16'h196E, 16'hFFF3,
      16'hB929, 16'h5520, 16'hE8B2, 16'h4A4A, 16'h7BDE, 16'hBFFF, 16'h8B5B, 16'hB6DA
   };

endpackage

>>> rtl/core/tcce_store.sv
module tcce_store #(
   parameter int DEPTH = 1000,
   parameter int AW    = 10
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  tcce_pkg::cell_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output tcce_pkg::cell_type rd_data
);
   import tcce_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/text_console_cell_engine.sv
// Channel   Ports                                   Direction  Transfer when
// request   start, busy, req_item                   in         start high, busy low
// response  rsp_strobe, rsp_item                    out        rsp_strobe high (one cycle)
// config    csr_we, csr_index, csr_wdata            in         csr_we high
//
// Put, newline and set cursor execute directly; an in-range read adds one registered store
// read, an out-of-range read does not. Clear and a scrolling put or newline walk the whole
// store, and the single store write port moves one cell per cycle.
// After reset the block sweeps all ROWS*COLUMNS cells to spaces (busy high) before the
// first request transfer; config writes are taken during that sweep.
// Every request yields exactly one response; the receiver cannot stall it.
module text_console_cell_engine #(
   parameter int COLUMNS = 40,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  tcce_pkg::req_type                 req_item,
   output logic                              rsp_strobe,
   output tcce_pkg::rsp_type                 rsp_item,
   input  logic                              csr_we,
   input  logic [tcce_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcce_pkg::COLOR_W-1:0]      csr_wdata
);
   import tcce_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int KW    = $clog2(CELLS + 1);
   localparam int YW    = $clog2(ROWS);
   localparam int XW    = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CLEAR,
      ST_SCROLL
   } state_type;

   state_type            state_ff;
   req_type              req_ff;
   rsp_type              rsp_ff;
   logic                 rsp_strobe_ff;
   logic [YW-1:0]        cur_y_ff;
   logic [XW-1:0]        cur_x_ff;
   logic [KW-1:0]        k_ff;          // sweep counter shared by clear and scroll
   logic                 fill_zero_ff;  // reset sweep: zero colors, no response
   logic [COLOR_W-1:0]   fg_ff;
   logic [COLOR_W-1:0]   bg_ff;

   // Next values computed while executing a request.
   logic [YW-1:0]        cur_y_in;
   logic [XW-1:0]        cur_x_in;
   logic                 scroll_in;
   rsp_type              rsp_in;

   logic [AW-1:0]        cur_idx;
   logic [AW-1:0]        req_idx;
   logic                 last_row;
   logic                 last_col;
   logic                 req_row_ok;
   logic                 req_col_ok;
   cell_type             fill_cell;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   cell_type             wr_data;
   logic [AW-1:0]        rd_addr;
   cell_type             rd_data;

   assign cur_idx    = AW'(32'(cur_y_ff) * COLUMNS + 32'(cur_x_ff));
   assign req_idx    = AW'(32'(req_ff.row) * COLUMNS + 32'(req_ff.column));
   assign last_row   = (cur_y_ff == YW'(ROWS - 1));
   assign last_col   = (cur_x_ff == XW'(COLUMNS - 1));
   assign req_row_ok = (req_ff.row < ROWCOL_W'(ROWS));
   assign req_col_ok = (req_ff.column < ROWCOL_W'(COLUMNS));

   always_comb begin
      fill_cell.code = CODE_SPACE;
      fill_cell.fg   = fill_zero_ff ? '0 : fg_ff;
      fill_cell.bg   = fill_zero_ff ? '0 : bg_ff;
   end

   // Cursor update and response contents for the request held in req_ff.
   always_comb begin
      cur_y_in  = cur_y_ff;
      cur_x_in  = cur_x_ff;
      scroll_in = 1'b0;
      rsp_in    = '0;
      unique case (req_ff.op)
         OP_PUT: begin
            if (req_ff.code == CODE_NEWLINE || last_col) begin
               // Return to column 0; scroll on the last row, else move down.
               cur_x_in = '0;
               if (last_row) begin
                  scroll_in = 1'b1;
               end else begin
                  cur_y_in = cur_y_ff + 1'b1;
               end
            end else begin
               cur_x_in = cur_x_ff + 1'b1;
            end
            if (req_ff.code != CODE_NEWLINE) begin
               // Report the cell as written, before any scroll.
               rsp_in.cell_valid  = 1'b1;
               rsp_in.cell_row    = CROW_W'(cur_y_ff);
               rsp_in.cell_column = CCOL_W'(cur_x_ff);
               rsp_in.cell_code   = req_ff.code;
               rsp_in.cell_fg     = fg_ff;
               rsp_in.cell_bg     = bg_ff;
               rsp_in.fg_rgb565   = PALETTE[fg_ff];
               rsp_in.bg_rgb565   = PALETTE[bg_ff];
            end
         end
         OP_SET_CURSOR: begin
            if (req_col_ok) begin
               cur_x_in = XW'(req_ff.column);
            end
            if (req_row_ok) begin
               cur_y_in = YW'(req_ff.row);
            end
         end
         OP_CLEAR: begin
            cur_x_in = '0;
            cur_y_in = '0;
         end
         OP_READ: begin
            // Cell fields come from the registered store read in the next cycle, in ST_READ.
         end
         default: begin
         end
      endcase
      rsp_in.cursor_row    = CROW_W'(cur_y_in);
      rsp_in.cursor_column = CCOL_W'(cur_x_in);
      rsp_in.scrolled      = scroll_in;
   end

   // Store port control. During a scroll, step k reads cell k+COLUMNS and writes cell k-1
   // with the data read at step k-1, or with a space for the last row.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_idx;
      wr_data = '{code: req_ff.code, fg: fg_ff, bg: bg_ff};
      rd_addr = req_idx;
      unique case (state_ff)
         ST_EXEC: begin
            wr_en = (req_ff.op == OP_PUT) && (req_ff.code != CODE_NEWLINE);
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(k_ff);
            wr_data = fill_cell;
         end
         ST_SCROLL: begin
            rd_addr = (k_ff < KW'(CELLS - COLUMNS)) ? AW'(32'(k_ff) + COLUMNS) : '0;
            wr_en   = (k_ff != '0);
            wr_addr = AW'(k_ff - 1'b1);
            wr_data = (k_ff <= KW'(CELLS - COLUMNS)) ? rd_data : fill_cell;
         end
         ST_IDLE, ST_READ: begin
         end
         default: begin
         end
      endcase
   end

   tcce_store #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         k_ff          <= '0;
         fill_zero_ff  <= 1'b1;
         cur_y_ff      <= '0;
         cur_x_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         fg_ff         <= FG_RESET;
         bg_ff         <= BG_RESET;
      end else begin
         rsp_strobe_ff <= 1'b0;

         if (csr_we) begin
            if (csr_index == CSR_FG_COLOR) begin
               fg_ff <= csr_wdata;
            end else if (csr_index == CSR_BG_COLOR) begin
               bg_ff <= csr_wdata;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               cur_y_ff <= cur_y_in;
               cur_x_ff <= cur_x_in;
               rsp_ff   <= rsp_in;
               k_ff     <= '0;
               if (req_ff.op == OP_CLEAR) begin
                  fill_zero_ff <= 1'b0;
                  state_ff     <= ST_CLEAR;
               end else if (req_ff.op == OP_READ && req_row_ok && req_col_ok) begin
                  state_ff <= ST_READ;
               end else if (scroll_in) begin
                  fill_zero_ff <= 1'b0;
                  state_ff     <= ST_SCROLL;
               end else begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_READ: begin
               // Store data for the addressed cell has landed.
               rsp_ff.cell_valid  <= 1'b1;
               rsp_ff.cell_row    <= CROW_W'(req_ff.row);
               rsp_ff.cell_column <= CCOL_W'(req_ff.column);
               rsp_ff.cell_code   <= rd_data.code;
               rsp_ff.cell_fg     <= rd_data.fg;
               rsp_ff.cell_bg     <= rd_data.bg;
               rsp_ff.fg_rgb565   <= PALETTE[rd_data.fg];
               rsp_ff.bg_rgb565   <= PALETTE[rd_data.bg];
               rsp_strobe_ff      <= 1'b1;
               state_ff           <= ST_IDLE;
            end
            ST_CLEAR: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == KW'(CELLS - 1)) begin
                  // The power-on sweep has no request behind it: drop the response.
                  rsp_strobe_ff <= !fill_zero_ff;
                  fill_zero_ff  <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_SCROLL: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == KW'(CELLS)) begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // A response only goes out as the block returns to idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("response strobe while sequencer is not idle");

   // Cursor stays on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_y_ff) < ROWS) && (32'(cur_x_ff) < COLUMNS))
      else $error("cursor outside the screen");

   // A response without a cell carries zero cell fields.
   a_empty_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ff.cell_valid |->
         rsp_ff.cell_code == '0 && rsp_ff.fg_rgb565 == '0 && rsp_ff.bg_rgb565 == '0)
      else $error("cell fields set on a response without a cell");

   // A scroll always leaves the cursor at column 0 of the last row.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.scrolled |->
         rsp_ff.cursor_column == '0 && cur_y_ff == YW'(ROWS - 1))
      else $error("scroll left the cursor off the start of the last row");

   // A request transfer starts execution on the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_EXEC)
      else $error("accepted request did not enter execution");

endmodule

>>> tb/tb_text_console_cell_engine.sv
`timescale 1ns / 100ps

module tb_text_console_cell_engine;
   import tcce_pkg::*;

   localparam int COLUMNS = 40;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   // A scrolling put walks the whole store; the clearing sweep after reset does too.
   // Size the watchdog limit in whole-store walks of slack before calling a wait hung.
   localparam int SETTLE_CYCLES  = CELLS + 8;
   localparam int WATCHDOG_LIMIT = 5 * CELLS;

   localparam int ITEMS_PER_SETTING = 133;
   localparam int SETTINGS_PER_PHASE = 4;

   // Register indexes past the two real registers; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   // Sixteen-entry RGB565 palette, kept here so the check does not lean on the package.
   localparam logic [RGB_W-1:0] RGB565_LUT [16] = '{
      16'h0000, 16'hFFFF, 16'hA208, 16'h7BFE, 16'hB0B0, 16'h4FEC, 16'h196E, 16'hFFF3,
      16'hB929, 16'h5520, 16'hE8B2, 16'h4A4A, 16'h7BDE, 16'hBFFF, 16'h8B5B, 16'hB6DA
   };

   // Console mirror: tracks the cell store, cursor and colors, predicts each
   // response and checks the responses in order.
   class console_scoreboard;
      cell_type            cells [CELLS];
      int                  cur_row;
      int                  cur_col;
      logic [COLOR_W-1:0]  fg_sel;
      logic [COLOR_W-1:0]  bg_sel;
      rsp_type             awaited_rsp [$];
      int                  mismatches;
      int                  puts;
      int                  reads;
      int                  clears;
      int                  scrolls;
      int                  cursor_sets;

      function new();
         for (int i = 0; i < CELLS; i++) begin
            cells[i].code = CODE_SPACE;
            cells[i].fg   = '0;
            cells[i].bg   = '0;
         end
         cur_row = 0;
         cur_col = 0;
         fg_sel  = COLOR_W'(14);
         bg_sel  = COLOR_W'(6);
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
         if (idx == CSR_FG_COLOR)
            fg_sel = value;
         else if (idx == CSR_BG_COLOR)
            bg_sel = value;
      endfunction

      function void blank_cells(int first, int count);
         for (int i = first; i < first + count; i++) begin
            cells[i].code = CODE_SPACE;
            cells[i].fg   = fg_sel;
            cells[i].bg   = bg_sel;
         end
      endfunction

      // Move down a row, or shift the screen up when already on the bottom row.
      function logic line_down();
         cur_col = 0;
         if (cur_row >= ROWS - 1) begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
               cells[i] = cells[i + COLUMNS];
            blank_cells(CELLS - COLUMNS, COLUMNS);
            return 1'b1;
         end
         cur_row++;
         return 1'b0;
      endfunction

      function void show_cell(inout rsp_type o, input int row, input int col);
         cell_type c;
         c = cells[row * COLUMNS + col];
         o.cell_valid  = 1'b1;
         o.cell_row    = CROW_W'(row);
         o.cell_column = CCOL_W'(col);
         o.cell_code   = c.code;
         o.cell_fg     = c.fg;
         o.cell_bg     = c.bg;
         o.fg_rgb565   = RGB565_LUT[c.fg];
         o.bg_rgb565   = RGB565_LUT[c.bg];
      endfunction

      function rsp_type step_console(req_type r);
         rsp_type o;
         int      idx;
         o = '0;
         case (r.op)
            OP_PUT: begin
               puts++;
               if (r.code == CODE_NEWLINE) begin
                  o.scrolled = line_down();
               end else begin
                  idx = cur_row * COLUMNS + cur_col;
                  cells[idx].code = r.code;
                  cells[idx].fg   = fg_sel;
                  cells[idx].bg   = bg_sel;
                  // report the cell as written, before any scroll moves it
                  show_cell(o, cur_row, cur_col);
                  cur_col++;
                  if (cur_col >= COLUMNS)
                     o.scrolled = line_down();
               end
            end
            OP_SET_CURSOR: begin
               cursor_sets++;
               if (r.column < COLUMNS)
                  cur_col = r.column;
               if (r.row < ROWS)
                  cur_row = r.row;
            end
            OP_CLEAR: begin
               clears++;
               blank_cells(0, CELLS);
               cur_row = 0;
               cur_col = 0;
            end
            default: begin
               reads++;
               if (r.row < ROWS && r.column < COLUMNS)
                  show_cell(o, r.row, r.column);
            end
         endcase
         if (o.scrolled)
            scrolls++;
         o.cursor_row    = CROW_W'(cur_row);
         o.cursor_column = CCOL_W'(cur_col);
         return o;
      endfunction

      function void note_command(req_type r);
         awaited_rsp.push_back(step_console(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         string   bad;
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %h with nothing pending", got);
            return;
         end
         want = awaited_rsp.pop_front();
         bad  = "";
         if (got.cell_valid    !== want.cell_valid)    bad = {bad, " cell_valid"};
         if (got.cell_row      !== want.cell_row)      bad = {bad, " cell_row"};
         if (got.cell_column   !== want.cell_column)   bad = {bad, " cell_column"};
         if (got.cell_code     !== want.cell_code)     bad = {bad, " cell_code"};
         if (got.cell_fg       !== want.cell_fg)       bad = {bad, " cell_fg"};
         if (got.cell_bg       !== want.cell_bg)       bad = {bad, " cell_bg"};
         if (got.fg_rgb565     !== want.fg_rgb565)     bad = {bad, " fg_rgb565"};
         if (got.bg_rgb565     !== want.bg_rgb565)     bad = {bad, " bg_rgb565"};
         if (got.cursor_row    !== want.cursor_row)    bad = {bad, " cursor_row"};
         if (got.cursor_column !== want.cursor_column) bad = {bad, " cursor_column"};
         if (got.scrolled      !== want.scrolled)      bad = {bad, " scrolled"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch in%s: expected %h, got %h", bad, want, got);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_item  = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_item;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [COLOR_W-1:0]    csr_wdata = '0;

   console_scoreboard sb = new();
   int                idle_cycles = 0;
   int                color_settings = 0;

   text_console_cell_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sample every channel at the edge, before the block's own updates land.
   // Check responses first: a response can never belong to a transfer of the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_response(rsp_item);
         if (start && !busy)
            sb.note_command(req_item);
         if (csr_we)
            sb.set_register(csr_index, csr_wdata);
      end
   end

   // Watchdog: count edges with neither a command transfer nor a response.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic req_type cmd(op_type op, int code, int row, int col);
      req_type r;
      r.op     = op;
      r.code   = CODE_W'(code);
      r.row    = ROWCOL_W'(row);
      r.column = ROWCOL_W'(col);
      return r;
   endfunction

   // Mostly typing with cursor moves near the bottom rows so that wraps and
   // scrolls come often; raw codes and out-of-range coordinates as noise.
   function automatic req_type random_command();
      req_type r;
      int      pick;
      int      flavor;
      r.op     = OP_PUT;
      r.code   = CODE_W'($urandom());
      r.row    = ROWCOL_W'($urandom());
      r.column = ROWCOL_W'($urandom());
      pick   = $urandom_range(99);
      flavor = $urandom_range(99);
      if (pick < 58) begin
         if (flavor < 70)
            r.code = CODE_W'($urandom_range(32, 126));
         else if (flavor < 80)
            r.code = CODE_NEWLINE;
      end else if (pick < 74) begin
         r.op = OP_SET_CURSOR;
         if (flavor < 80) begin
            r.row    = ROWCOL_W'(flavor < 40 ? ROWS - 1 : $urandom_range(ROWS - 1));
            r.column = ROWCOL_W'(flavor < 55 ? $urandom_range(COLUMNS - 6, COLUMNS - 1)
                                             : $urandom_range(COLUMNS - 1));
         end
      end else if (pick < 75) begin
         r.op = OP_CLEAR;
      end else begin
         r.op = OP_READ;
         if (flavor < 80) begin
            r.row    = ROWCOL_W'($urandom_range(ROWS - 1));
            r.column = ROWCOL_W'($urandom_range(COLUMNS - 1));
         end
      end
      return r;
   endfunction

   // Present one command and hold it until the transfer; idle first now and then.
   task automatic send_command(input req_type r, input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start, let every pending response arrive, then let the block finish its walk.
   task automatic wait_idle();
      start <= 1'b0;
      while (sb.awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      csr_we    <= 1'b1;
      csr_index <= CSR_FG_COLOR;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= CSR_BG_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      csr_index <= CSR_SPARE_LO;
      csr_wdata <= COLOR_W'($urandom());
      @(posedge clock);
      csr_index <= CSR_SPARE_HI;
      csr_wdata <= COLOR_W'($urandom());
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      color_settings++;
   endtask

   initial begin
      req_type directed [$];
      int      idle_pct;
      int      setting;
      int      failures;

      // hold reset, then release it at an edge
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed commands at the reset colors: untouched cell, extreme codes,
      // wrap at the line end, partial and rejected cursor moves, writing the
      // last cell, newline on the bottom row, reads out of range, clear.
      directed.push_back(cmd(OP_READ, 0, 0, 0));
      directed.push_back(cmd(OP_PUT, 65, 0, 0));
      directed.push_back(cmd(OP_PUT, 0, 255, 255));
      directed.push_back(cmd(OP_PUT, 21'h1FFFFF, 0, 0));
      directed.push_back(cmd(OP_PUT, 21'h10FFFF, 0, 0));
      directed.push_back(cmd(OP_PUT, CODE_NEWLINE, 200, 200));
      directed.push_back(cmd(OP_READ, 0, 0, 2));
      directed.push_back(cmd(OP_SET_CURSOR, 0, 0, COLUMNS - 1));
      directed.push_back(cmd(OP_PUT, 66, 0, 0));
      directed.push_back(cmd(OP_SET_CURSOR, 0, 255, 10));
      directed.push_back(cmd(OP_SET_CURSOR, 0, 3, 255));
      directed.push_back(cmd(OP_SET_CURSOR, 21'h1FFFFF, ROWS, COLUMNS));
      directed.push_back(cmd(OP_SET_CURSOR, 0, ROWS - 1, COLUMNS - 1));
      directed.push_back(cmd(OP_PUT, 67, 0, 0));
      directed.push_back(cmd(OP_READ, 0, ROWS - 2, COLUMNS - 1));
      directed.push_back(cmd(OP_READ, 0, ROWS - 1, 0));
      directed.push_back(cmd(OP_SET_CURSOR, 0, ROWS - 1, 5));
      directed.push_back(cmd(OP_PUT, CODE_NEWLINE, 0, 0));
      directed.push_back(cmd(OP_READ, 0, ROWS, 0));
      directed.push_back(cmd(OP_READ, 0, 0, COLUMNS));
      directed.push_back(cmd(OP_READ, 21'h1FFFFF, 255, 255));
      directed.push_back(cmd(OP_CLEAR, 21'h1FFFFF, 255, 255));
      directed.push_back(cmd(OP_READ, 0, ROWS - 1, COLUMNS - 1));
      directed.push_back(cmd(OP_READ, 0, 12, 20));
      foreach (directed[i])
         send_command(directed[i], 0);

      // Three pacing phases: light sender gaps, heavy gaps, none. Each phase
      // runs through several color settings; the first phase takes the extremes.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 29 : (phase == 1) ? 72 : 0;
         for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
            setting = phase * SETTINGS_PER_PHASE + s;
            wait_idle();
            case (setting)
               0:       write_colors(4'd0, 4'd15);
               1:       write_colors(4'd15, 4'd0);
               2:       write_colors(4'd0, 4'd0);
               3:       write_colors(4'd15, 4'd15);
               default: write_colors(COLOR_W'($urandom()), COLOR_W'($urandom()));
            endcase
            for (int k = 0; k < ITEMS_PER_SETTING; k++)
               send_command(random_command(), idle_pct);
         end
      end

      // drain and give the block time to show any stray response
      wait_idle();

      failures = sb.mismatches + sb.awaited_rsp.size();
      if (sb.awaited_rsp.size() != 0)
         $display("%0d responses never arrived", sb.awaited_rsp.size());
      $display("covered %0d puts, %0d cursor moves, %0d reads, %0d clears, %0d scrolls",
               sb.puts, sb.cursor_sets, sb.reads, sb.clears, sb.scrolls);
      $display("across %0d color settings; %0d mismatches", color_settings, sb.mismatches);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
